FILE: hdl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared types and codes of the sorted list engine
// Operation and status codes, the sequencer states and the control bundle
// that the top level broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_ENUM   = 2'd2,
		KIND_LENGTH = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NOTFOUND = 2'd1,
		STATUS_FULL     = 2'd2,
		STATUS_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPLY,
		ST_ENUM
	} state_t;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 6;

	// Broadcast to all cells: capture loads the compare flags, ins and del
	// commit a shift of the chain.
	typedef struct packed {
		logic               capture;
		logic               ins;
		logic               del;
		logic [VALUE_W-1:0] value;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell: one slot of the sorted chain
// Holds one value, compares it with the broadcast operand and shifts toward
// either neighbor when an insert or a delete is committed.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  sle_pkg::cell_ctl_t     ctl,
	input  wire                          occ,
	input  wire                          lt_left,
	input  wire                          seen_in,
	input  wire  [sle_pkg::VALUE_W-1:0]  left_value,
	input  wire  [sle_pkg::VALUE_W-1:0]  right_value,
	output logic                         lt,
	output logic                         seen_out,
	output logic [sle_pkg::VALUE_W-1:0]  value
);

	logic [sle_pkg::VALUE_W-1:0] val_q;
	logic                        lt_q;
	logic                        eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.capture) begin
			lt_q <= occ && ($signed(val_q) < $signed(ctl.value));
			eq_q <= occ && (val_q == ctl.value);
		end
	end

	// The list is sorted, so the cells that hold smaller values form a prefix.
	// The first cell outside it takes the new value, the rest take their left
	// neighbor's. On delete every cell at or after the first match pulls in
	// its right neighbor.
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt_q) begin
			val_q <= lt_left ? ctl.value : left_value;
		end else if (ctl.del && seen_out) begin
			val_q <= right_value;
		end
	end

	assign lt       = lt_q;
	assign seen_out = seen_in | eq_q;
	assign value    = val_q;

endmodule

`default_nettype wire

FILE: hdl/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine: sorted list of signed 32-bit values
// A chain of CAPACITY cells keeps the values in ascending order and serves
// insert, delete, enumerate and length requests.
// ----------------------------------------------------------------------------
// Each cell compares its value with the operand in the cycle the request beat
// is accepted and commits its shift in ST_APPLY once the output register is
// free. Enumerate streams the stored values from lowest to highest with tlast
// on the final beat; an empty list gives a single beat with status empty. A
// result beat waits in the output register while the next request is
// accepted. The list comes out of reset empty, with no clearing pass.
`default_nettype none

module sorted_list_engine #(
	parameter int CAPACITY = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // [31:0] value
	input  wire  [1:0]  s_tuser,   // [1:0] kind
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [31:0] element, [37:32] count
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int VW = sle_pkg::VALUE_W;

	sle_pkg::state_t  state_q, state_d;
	sle_pkg::kind_t   kind_q;
	logic [VW-1:0]    value_q;
	logic [CW-1:0]    count_q, count_d;
	logic [IW-1:0]    idx_q, idx_d;

	logic                     ovalid_q;
	sle_pkg::status_t         ostatus_q, ostatus_d;
	logic [VW-1:0]            oelem_q, oelem_d;
	logic [sle_pkg::COUNT_W-1:0] ocount_q;
	logic                     olast_q, olast_d;
	logic                     load_out;

	logic                     accept;
	logic                     out_free;
	logic                     full;
	logic                     found;
	sle_pkg::cell_ctl_t       ctl;

	logic [VW-1:0]            cell_val [CAPACITY];
	logic [CAPACITY:0]        lt_chain;
	logic [CAPACITY:0]        seen_chain;

	assign s_tready = (state_q == sle_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !ovalid_q || m_tready;
	assign full     = (count_q == CW'(CAPACITY));
	assign found    = seen_chain[CAPACITY];

	assign ctl.capture = accept;
	assign ctl.value   = accept ? s_tdata[VW-1:0] : value_q;
	assign ctl.ins     = (state_q == sle_pkg::ST_APPLY) && out_free &&
	                     (kind_q == sle_pkg::KIND_INSERT) && !full;
	assign ctl.del     = (state_q == sle_pkg::ST_APPLY) && out_free &&
	                     (kind_q == sle_pkg::KIND_DELETE) && found;

	assign lt_chain[0]   = 1'b1;
	assign seen_chain[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sle_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.occ         (count_q > CW'(i)),
			.lt_left     (lt_chain[i]),
			.seen_in     (seen_chain[i]),
			.left_value  (cell_val[(i == 0) ? 0 : i - 1]),
			.right_value (cell_val[(i == CAPACITY - 1) ? i : i + 1]),
			.lt          (lt_chain[i+1]),
			.seen_out    (seen_chain[i+1]),
			.value       (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sle_pkg::ST_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (load_out) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= sle_pkg::kind_t'(s_tuser);
			value_q <= s_tdata[VW-1:0];
		end
		if (load_out) begin
			ostatus_q <= ostatus_d;
			oelem_q   <= oelem_d;
			ocount_q  <= sle_pkg::COUNT_W'(count_d);
			olast_q   <= olast_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		load_out  = 1'b0;
		ostatus_d = sle_pkg::STATUS_OK;
		oelem_d   = value_q;
		olast_d   = 1'b1;
		case (state_q)
			sle_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = sle_pkg::ST_APPLY;
				end
			end
			sle_pkg::ST_APPLY: begin
				if (out_free) begin
					state_d  = sle_pkg::ST_IDLE;
					load_out = 1'b1;
					case (kind_q)
						sle_pkg::KIND_INSERT: begin
							if (full) begin
								ostatus_d = sle_pkg::STATUS_FULL;
							end else begin
								count_d = count_q + CW'(1);
							end
						end
						sle_pkg::KIND_DELETE: begin
							if (found) begin
								count_d = count_q - CW'(1);
							end else begin
								ostatus_d = sle_pkg::STATUS_NOTFOUND;
							end
						end
						sle_pkg::KIND_ENUM: begin
							if (count_q == '0) begin
								ostatus_d = sle_pkg::STATUS_EMPTY;
								oelem_d   = '0;
							end else begin
								load_out = 1'b0;
								idx_d    = '0;
								state_d  = sle_pkg::ST_ENUM;
							end
						end
						default: begin
						end
					endcase
				end
			end
			sle_pkg::ST_ENUM: begin
				if (out_free) begin
					load_out = 1'b1;
					oelem_d  = cell_val[idx_q];
					olast_d  = (CW'(idx_q) == count_q - CW'(1));
					idx_d    = idx_q + IW'(1);
					if (olast_d) begin
						state_d = sle_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sle_pkg::ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {2'b00, ocount_q, oelem_q};
	assign m_tuser  = ostatus_q;
	assign m_tlast  = olast_q;

endmodule

`default_nettype wire

FILE: hdl/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker: port-level checks of the sorted list engine
// Checks stalled beats, status beats against the count, enumerate streams.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_checker #(
	parameter int CAPACITY = 32
) (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire [1:0]  m_tuser,
	input wire        m_tlast
);

	logic beat;
	assign beat = m_tvalid && m_tready;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		beat && m_tuser == sle_pkg::STATUS_FULL |->
		m_tlast && m_tdata[37:32] == 6'(CAPACITY))
		else $error("full status with a count below capacity");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		beat && m_tuser == sle_pkg::STATUS_EMPTY |->
		m_tlast && m_tdata[37:32] == 6'd0 && m_tdata[31:0] == 32'd0)
		else $error("empty status on a non-empty list");

	a_notfound: assert property (@(posedge clk) disable iff (!arst_n)
		beat && m_tuser == sle_pkg::STATUS_NOTFOUND |-> m_tlast)
		else $error("not-found status on a non-final beat");

	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		beat && !m_tlast |=> m_tvalid && m_tuser == sle_pkg::STATUS_OK)
		else $error("enumerate stream broken before its final beat");

endmodule

bind sorted_list_engine sle_checker #(.CAPACITY(CAPACITY)) u_sle_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire
